[sv/mur_absorbing_boundary_update_assert.svh]
// Assertion macros shared by the absorbing boundary checker.
// Each macro builds one labeled concurrent assertion on a given clock.
`ifndef MUR_ABSORBING_BOUNDARY_UPDATE_ASSERT_SVH
`define MUR_ABSORBING_BOUNDARY_UPDATE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define MUR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define MUR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define MUR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mur_abc_pkg.sv]
// Shared constants and types for the Mur absorbing boundary block.
// No dependencies.
`default_nettype none

package mur_abc_pkg;

    localparam int MAX_DIM    = 64;
    localparam int NUM_FACES  = 6;
    localparam int HIST_DEPTH = 2 * NUM_FACES * MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    localparam int FACE_W     = 3;
    localparam int FACE_CODES = 1 << FACE_W;
    localparam int COORD_W    = 6;
    localparam int FIELD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int DIFF_W     = FIELD_W + 1;
    localparam int PROD_W     = DIFF_W + COEF_W;
    localparam int COEF_FRAC  = 15;
    localparam int SUM_W      = PROD_W - COEF_FRAC + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COEF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_COEF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_ENABLE   = 1'd1;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [ADDR_W-1:0]  addr;
        logic [FIELD_W-1:0] wdata;
    } hist_req_t;

endpackage

`default_nettype wire

[sv/mur_abc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module mur_abc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/mur_abc_hist.sv]
// History store of inward field values with its post-reset clearing pass.
// Depends on mur_abc_pkg and mur_abc_ram.
`default_nettype none

module mur_abc_hist (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mur_abc_pkg::hist_req_t        req,
    output logic                               ready,
    output logic [mur_abc_pkg::FIELD_W-1:0]    rdata
);

    import mur_abc_pkg::*;

    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [FIELD_W-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(HIST_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign we    = clearing_reg || req.wr_en;
    assign waddr = clearing_reg ? clr_addr_reg : req.addr;
    assign wdata = clearing_reg ? '0 : req.wdata;
    assign ready = !clearing_reg;

    mur_abc_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (HIST_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (req.rd_en),
        .raddr (req.addr),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

[sv/mur_absorbing_boundary_update.sv]
// First-order Mur absorbing boundary update, three-stage pipeline.
// One item per cycle when the output is not stalled and the history store is ready.
// Stages: check/address/difference, multiply with history read, add/saturate.
// After reset all 49152 history entries are zeroed with s_ready low; configuration writes
// are taken at all times out of reset. Valid and configuration registers reset to zero.
`default_nettype none

module mur_absorbing_boundary_update (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      cfg_wr_en,
    input  wire logic        [mur_abc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [mur_abc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                                      s_valid,
    output logic                                           s_ready,
    input  wire logic        [mur_abc_pkg::FACE_W-1:0]     s_face,
    input  wire logic                                      s_component,
    input  wire logic        [mur_abc_pkg::COORD_W-1:0]    s_coord_a,
    input  wire logic        [mur_abc_pkg::COORD_W-1:0]    s_coord_b,
    input  wire logic signed [mur_abc_pkg::FIELD_W-1:0]    s_edge_value,
    input  wire logic signed [mur_abc_pkg::FIELD_W-1:0]    s_inner_value,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic signed      [mur_abc_pkg::FIELD_W-1:0]    m_new_edge_value,
    output logic                                           m_applied
);

    import mur_abc_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    logic signed [COEF_W-1:0] coef_reg;
    logic [NUM_FACES-1:0]     face_en_reg;

    logic s1_en, s2_en, s3_en;
    logic hist_ready;
    logic [FIELD_W-1:0] hist_rdata;
    hist_req_t hist_req;

    // stage 1
    logic                      s1_valid_reg, s1_ok_reg;
    logic [ADDR_W-1:0]         s1_addr_reg;
    logic signed [DIFF_W-1:0]  s1_diff_reg;
    logic signed [FIELD_W-1:0] s1_edge_reg, s1_inner_reg;
    logic [FACE_CODES-1:0]     face_en_ext;
    logic                      s1_ok_next;
    logic [ADDR_W-1:0]         s1_addr_next;
    logic signed [DIFF_W-1:0]  s1_diff_next;

    // stage 2
    logic                      s2_valid_reg, s2_ok_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg;
    logic signed [FIELD_W-1:0] s2_edge_reg;
    logic signed [PROD_W-1:0]  s2_prod_next;

    // stage 3
    logic                      m_valid_reg, m_applied_reg;
    logic signed [FIELD_W-1:0] m_value_reg;
    logic signed [SUM_W-1:0]   sum;
    logic signed [FIELD_W-1:0] m_value_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg    <= '0;
            face_en_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BOUNDARY_COEF: coef_reg    <= $signed(cfg_wdata[COEF_W-1:0]);
                CFG_FACE_ENABLE:   face_en_reg <= cfg_wdata[NUM_FACES-1:0];
            endcase
        end
    end

    assign s3_en   = !m_valid_reg || m_ready;
    assign s2_en   = !s2_valid_reg || s3_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s_ready = s1_en && hist_ready;

    assign face_en_ext  = FACE_CODES'(face_en_reg);
    assign s1_ok_next   = face_en_ext[s_face]
                          && (32'(s_coord_a) < 32'(MAX_DIM))
                          && (32'(s_coord_b) < 32'(MAX_DIM));
    assign s1_addr_next = ADDR_W'((32'({s_face, s_component}) * 32'(MAX_DIM)
                          + 32'(s_coord_a)) * 32'(MAX_DIM) + 32'(s_coord_b));
    assign s1_diff_next = DIFF_W'(s_inner_value) - DIFF_W'(s_edge_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= s_valid && s_ready;
        end
        if (s_valid && s_ready) begin
            s1_ok_reg    <= s1_ok_next;
            s1_addr_reg  <= s1_addr_next;
            s1_diff_reg  <= s1_diff_next;
            s1_edge_reg  <= s_edge_value;
            s1_inner_reg <= s_inner_value;
        end
    end

    // read old history and store the new inward value as the item advances
    assign hist_req.rd_en = s1_valid_reg && s1_ok_reg && s2_en;
    assign hist_req.wr_en = s1_valid_reg && s1_ok_reg && s2_en;
    assign hist_req.addr  = s1_addr_reg;
    assign hist_req.wdata = s1_inner_reg;

    mur_abc_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hist_req),
        .ready   (hist_ready),
        .rdata   (hist_rdata)
    );

    assign s2_prod_next = PROD_W'(s1_diff_reg) * PROD_W'(coef_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_en && s1_valid_reg) begin
            s2_ok_reg   <= s1_ok_reg;
            s2_prod_reg <= s2_prod_next;
            s2_edge_reg <= s1_edge_reg;
        end
    end

    assign sum = SUM_W'($signed(hist_rdata))
                 + SUM_W'($signed(s2_prod_reg[PROD_W-1:COEF_FRAC]));

    always_comb begin
        priority if (!s2_ok_reg) begin
            m_value_next = s2_edge_reg;
        end else if (sum > SAT_MAX) begin
            m_value_next = SAT_MAX[FIELD_W-1:0];
        end else if (sum < SAT_MIN) begin
            m_value_next = SAT_MIN[FIELD_W-1:0];
        end else begin
            m_value_next = sum[FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s3_en) begin
            m_valid_reg <= s2_valid_reg;
        end
        if (s3_en && s2_valid_reg) begin
            m_value_reg   <= m_value_next;
            m_applied_reg <= s2_ok_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_new_edge_value = m_value_reg;
    assign m_applied        = m_applied_reg;

endmodule

`default_nettype wire

[sv/mur_abc_checker.sv]
// Port-level checker for the Mur absorbing boundary block, bound to the top.
// Depends on mur_abc_pkg and mur_absorbing_boundary_update_assert.svh.
`default_nettype none

`include "mur_absorbing_boundary_update_assert.svh"

module mur_abc_checker (
    input wire logic                                   aclk,
    input wire logic                                   aresetn,
    input wire logic                                   s_valid,
    input wire logic                                   s_ready,
    input wire logic                                   m_valid,
    input wire logic                                   m_ready,
    input wire logic signed [mur_abc_pkg::FIELD_W-1:0] m_new_edge_value,
    input wire logic                                   m_applied
);

    `MUR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_new_edge_value) && $stable(m_applied),
        "result item changed while stalled")

    `MUR_ASSERT_SAME(a_fill_latency, aclk, aresetn, $rose(m_valid),
        $past(s_valid && s_ready, 3), "result item without input item three cycles before")

    `MUR_ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !s_ready && !m_valid,
        "ports not quiet after reset")

endmodule

bind mur_absorbing_boundary_update mur_abc_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_new_edge_value (m_new_edge_value),
    .m_applied        (m_applied)
);

`default_nettype wire
